[rtl/ycocg420_pkg.sv]
// shared constants, types and register codes for the rgb to ycocg-r 4:2:0 converter
package ycocg420_pkg;

   localparam int MAX_PAIR_COLUMNS = 1024;
   localparam int ROW_PAIR_LIMIT   = 4096;
   localparam int SLOT_W           = $clog2(MAX_PAIR_COLUMNS);
   localparam int COL_W            = 11;
   localparam int ROW_W            = 13;
   localparam int CSR_DATA_W       = 13;
   localparam int PAIR_W           = 10;
   localparam int WORD_W           = 2 * PAIR_W;

   localparam logic [COL_W-1:0] MAX_COLS  = COL_W'(MAX_PAIR_COLUMNS);
   localparam logic [ROW_W-1:0] MAX_ROWS  = ROW_W'(ROW_PAIR_LIMIT);
   localparam logic [COL_W-1:0] RESET_COLS = COL_W'(320);
   localparam logic [ROW_W-1:0] RESET_ROWS = ROW_W'(240);
   localparam logic [11:0]      CHROMA_BIAS = 12'd1024;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [WORD_W-1:0] pair_word_type;

   typedef enum logic {
      CSR_PAIR_COLUMNS = 1'b0,
      CSR_PAIR_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          wr_en;
      slot_type      wr_slot;
      pair_word_type wr_word;
      logic          rd_en;
      slot_type      rd_slot;
   } line_ctl_type;

endpackage

[rtl/ycocg420_line_mem.sv]
// line store of even-row chroma pair sums, registered read
module ycocg420_line_mem (
   input  logic                         clock,
   input  ycocg420_pkg::line_ctl_type   ctl,
   output ycocg420_pkg::pair_word_type  rd_word
);
   import ycocg420_pkg::*;

   pair_word_type mem [MAX_PAIR_COLUMNS];
   pair_word_type rd_word_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_slot] <= ctl.wr_word;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[ctl.rd_slot];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

[rtl/rgb_to_ycocg_r_420.sv]
// rgb to ycocg-r converter with 4:2:0 chroma averaging over 2x2 blocks
// an accepted item passes through the stage 1 register and then the output register
// throughput: one item per clock while rsp is not stalled; the line store has separate
// read and write ports, and an entry is read at least two items after it was written
// reset clears counters, left chroma and both pipeline stages, and loads 320 x 240
// the line store is not cleared; it is written on even rows before any read
module rgb_to_ycocg_r_420 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // luma, orange_chroma, green_chroma
   output logic        rsp_tuser,   // chroma_valid
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [ycocg420_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ycocg420_pkg::*;

   logic [COL_W-1:0] pair_columns_ff;
   logic [ROW_W-1:0] pair_rows_ff;
   logic [COL_W-1:0] cols_sat;
   logic [ROW_W-1:0] rows_sat;

   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [8:0]       left_co_ff, left_cg_ff;

   logic       req_accept;
   logic       col_odd, row_odd, col_end, row_end;
   logic [7:0] red, green, blue;
   logic [8:0] co_px, cg_px;
   logic [7:0] t_px, luma_px;
   logic [PAIR_W-1:0] co_pair_in, cg_pair_in;

   line_ctl_type  line_ctl;
   pair_word_type held_word;

   logic              s1_valid_ff;
   logic              s1_advance;
   logic [7:0]        s1_luma_ff;
   logic              s1_chroma_ff;
   logic              s1_last_ff;
   logic [PAIR_W-1:0] s1_co_pair_ff, s1_cg_pair_ff;
   logic [11:0]       co_sum, cg_sum;
   logic [7:0]        orange_in, green_in;

   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic        rsp_user_ff, rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_columns_ff <= RESET_COLS;
         pair_rows_ff    <= RESET_ROWS;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAIR_COLUMNS: pair_columns_ff <= csr_wdata[COL_W-1:0];
            CSR_PAIR_ROWS:    pair_rows_ff    <= csr_wdata[ROW_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      if (pair_columns_ff == '0) cols_sat = COL_W'(1);
      else if (pair_columns_ff > MAX_COLS) cols_sat = MAX_COLS;
      else cols_sat = pair_columns_ff;
      if (pair_rows_ff == '0) rows_sat = ROW_W'(1);
      else if (pair_rows_ff > MAX_ROWS) rows_sat = MAX_ROWS;
      else rows_sat = pair_rows_ff;
   end

   assign req_accept = req_tvalid && req_tready;

   // lifting steps; t always lands in 0..255 so eight bits carry it
   assign red     = req_tdata[7:0];
   assign green   = req_tdata[15:8];
   assign blue    = req_tdata[23:16];
   assign co_px   = {1'b0, red} - {1'b0, blue};
   assign t_px    = blue + co_px[8:1];
   assign cg_px   = {1'b0, green} - {1'b0, t_px};
   assign luma_px = t_px + cg_px[8:1];

   assign co_pair_in = {left_co_ff[8], left_co_ff} + {co_px[8], co_px};
   assign cg_pair_in = {left_cg_ff[8], left_cg_ff} + {cg_px[8], cg_px};

   // position in the frame
   assign col_odd = column_count_ff[0];
   assign row_odd = row_count_ff[0];
   assign col_end = ({1'b0, column_count_ff} + (COL_W+1)'(1)) >= {cols_sat, 1'b0};
   assign row_end = ({1'b0, row_count_ff} + (ROW_W+1)'(1)) >= {rows_sat, 1'b0};

   always_comb begin
      column_count_in = column_count_ff + COL_W'(1);
      row_count_in    = row_count_ff;
      if (col_end) begin
         column_count_in = '0;
         row_count_in    = row_end ? '0 : row_count_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         left_co_ff      <= '0;
         left_cg_ff      <= '0;
      end else if (req_accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         if (!col_odd) begin
            left_co_ff <= co_px;
            left_cg_ff <= cg_px;
         end
      end
   end

   // even rows store the pair sums, odd rows fetch them back
   always_comb begin
      line_ctl.wr_en   = req_accept && col_odd && !row_odd;
      line_ctl.wr_slot = column_count_ff[SLOT_W:1];
      line_ctl.wr_word = {cg_pair_in, co_pair_in};
      line_ctl.rd_en   = req_accept && col_odd && row_odd;
      line_ctl.rd_slot = column_count_ff[SLOT_W:1];
   end

   ycocg420_line_mem u_line_mem (
      .clock   (clock),
      .ctl     (line_ctl),
      .rd_word (held_word)
   );

   // stage 1 waits for the line store read
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_luma_ff    <= luma_px;
         s1_chroma_ff  <= col_odd && row_odd;
         s1_last_ff    <= col_end && row_end;
         s1_co_pair_ff <= co_pair_in;
         s1_cg_pair_ff <= cg_pair_in;
      end
   end

   // only bits 10:3 of the biased sum are kept, which divides it by eight
   assign co_sum = {{2{s1_co_pair_ff[PAIR_W-1]}}, s1_co_pair_ff}
                 + {{2{held_word[PAIR_W-1]}}, held_word[PAIR_W-1:0]}
                 + CHROMA_BIAS;
   assign cg_sum = {{2{s1_cg_pair_ff[PAIR_W-1]}}, s1_cg_pair_ff}
                 + {{2{held_word[WORD_W-1]}}, held_word[WORD_W-1:PAIR_W]}
                 + CHROMA_BIAS;
   assign orange_in = s1_chroma_ff ? co_sum[10:3] : 8'd0;
   assign green_in  = s1_chroma_ff ? cg_sum[10:3] : 8'd0;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= {green_in, orange_in, s1_luma_ff};
         rsp_user_ff <= s1_chroma_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
